// ----- rtl/eht_pkg.sv -----
package eht_pkg;

  localparam int KeyW      = 32;
  localparam int PayW      = 64;
  localparam int CfgW      = 4;
  localparam int StatW     = 3;
  localparam int ResultCap = 8;
  localparam int CountW    = 4;

  localparam logic [StatW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatW-1:0] ST_MATCH     = 3'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatW-1:0] ST_NO_BUCKET = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TAKE,
    OP_DIR_RD,
    OP_BKT_RD,
    OP_ALLOC,
    OP_INS,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_CNT0,
    OP_DIR_RD_CNT,
    OP_SPL_DWR,
    OP_SLOT_RD,
    OP_SPL_SWR,
    OP_SPL_F1,
    OP_SPL_F2,
    OP_DBL_WR,
    OP_GD_INC,
    OP_CNT_INC,
    OP_HIT,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             cfg_we;
    logic [StatW-1:0] res;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic lookup;
    logic dir_v;
    logic fill_full;
    logic ld_lt_gd;
    logic used_full;
    logic gd_max;
    logic clr_last;
    logic cnt_eq_size;
    logic cnt_eq_fill;
    logic scan_end;
    logic hit;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/eht_ctrl.sv -----
module eht_ctrl import eht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [17:0] {
    S_CLEAR    = 18'h00001,
    S_IDLE     = 18'h00002,
    S_DIR_RD   = 18'h00004,
    S_DIR_CHK  = 18'h00008,
    S_BKT_CHK  = 18'h00010,
    S_SCAN_RD  = 18'h00020,
    S_SCAN_CHK = 18'h00040,
    S_LK_END   = 18'h00080,
    S_RESULT   = 18'h00100,
    S_SPL_LD   = 18'h00200,
    S_SPL_DRD  = 18'h00400,
    S_SPL_DWR  = 18'h00800,
    S_SPL_SRD  = 18'h01000,
    S_SPL_SWR  = 18'h02000,
    S_SPL_F1   = 18'h04000,
    S_SPL_F2   = 18'h08000,
    S_DBL_RD   = 18'h10000,
    S_DBL_WR   = 18'h20000
  } state_e;

  state_e           state_q, state_d;
  logic [StatW-1:0] res_q, res_d;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    cmd_o       = '{op: OP_NONE, cfg_we: 1'b0, res: ST_INSERTED, last: 1'b1};
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cfg_ready_o = 1'b1;
        cmd_o.op    = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = ~cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_DIR_RD;
        end
      end
      S_DIR_RD: begin
        cmd_o.op = OP_DIR_RD;
        state_d  = S_DIR_CHK;
      end
      S_DIR_CHK: begin
        if (sts_i.dir_v) begin
          cmd_o.op = OP_BKT_RD;
          state_d  = S_BKT_CHK;
        end else if (sts_i.lookup) begin
          state_d = S_LK_END;
        end else if (sts_i.used_full) begin
          res_d   = ST_NO_BUCKET;
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_ALLOC;
          res_d    = ST_INSERTED;
          state_d  = S_RESULT;
        end
      end
      S_BKT_CHK: begin
        if (sts_i.lookup) begin
          state_d = S_SCAN_RD;
        end else if (!sts_i.fill_full) begin
          cmd_o.op = OP_INS;
          res_d    = ST_INSERTED;
          state_d  = S_RESULT;
        end else if (sts_i.ld_lt_gd) begin
          if (sts_i.used_full) begin
            res_d   = ST_NO_BUCKET;
            state_d = S_RESULT;
          end else begin
            cmd_o.op = OP_SPLIT1;
            state_d  = S_SPL_LD;
          end
        end else if (sts_i.gd_max) begin
          res_d   = ST_FULL;
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_CNT0;
          state_d  = S_DBL_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = S_LK_END;
        end else begin
          cmd_o.op = OP_SLOT_RD;
          state_d  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts_i.hit) begin
          cmd_o.op = OP_CNT_INC;
          state_d  = S_SCAN_RD;
        end else if (!sts_i.pend_v || sts_i.out_free) begin
          // previous match goes out, this one is held until we know if it is the last
          cmd_o.op = OP_HIT;
          state_d  = S_SCAN_RD;
        end
      end
      S_LK_END: begin
        if (sts_i.out_free) begin
          cmd_o.op  = OP_OUT;
          cmd_o.res = sts_i.pend_v ? ST_MATCH : ST_NOT_FOUND;
          state_d   = S_IDLE;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.op  = OP_OUT;
          cmd_o.res = res_q;
          state_d   = S_IDLE;
        end
      end
      S_SPL_LD: begin
        cmd_o.op = OP_SPLIT2;
        state_d  = S_SPL_DRD;
      end
      S_SPL_DRD: begin
        if (sts_i.cnt_eq_size) begin
          cmd_o.op = OP_CNT0;
          state_d  = S_SPL_SRD;
        end else begin
          cmd_o.op = OP_DIR_RD_CNT;
          state_d  = S_SPL_DWR;
        end
      end
      S_SPL_DWR: begin
        cmd_o.op = OP_SPL_DWR;
        state_d  = S_SPL_DRD;
      end
      S_SPL_SRD: begin
        if (sts_i.cnt_eq_fill) begin
          state_d = S_SPL_F1;
        end else begin
          cmd_o.op = OP_SLOT_RD;
          state_d  = S_SPL_SWR;
        end
      end
      S_SPL_SWR: begin
        cmd_o.op = OP_SPL_SWR;
        state_d  = S_SPL_SRD;
      end
      S_SPL_F1: begin
        cmd_o.op = OP_SPL_F1;
        state_d  = S_SPL_F2;
      end
      S_SPL_F2: begin
        cmd_o.op = OP_SPL_F2;
        state_d  = S_DIR_RD;
      end
      S_DBL_RD: begin
        if (sts_i.cnt_eq_size) begin
          cmd_o.op = OP_GD_INC;
          state_d  = S_DIR_RD;
        end else begin
          cmd_o.op = OP_DIR_RD_CNT;
          state_d  = S_DBL_WR;
        end
      end
      S_DBL_WR: begin
        cmd_o.op = OP_DBL_WR;
        state_d  = S_DBL_RD;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    cmd_o.cfg_we = cfg_valid_i & cfg_ready_o;
    if (cmd_o.cfg_we) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

// ----- rtl/eht_dp.sv -----
module eht_dp import eht_pkg::*; #(
  parameter int MAX_DEPTH    = 8,
  parameter int BUCKET_SLOTS = 8,
  parameter int NUM_BUCKETS  = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   command_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [PayW-1:0]        payload_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [StatW-1:0]       status_o,
  output logic signed [KeyW-1:0] found_key_o,
  output logic [PayW-1:0]        found_payload_o,
  output logic                   last_o
);

  localparam int DirSize = 1 << MAX_DEPTH;
  localparam int DW      = MAX_DEPTH;
  localparam int GDW     = $clog2(MAX_DEPTH + 1);
  localparam int BW      = $clog2(NUM_BUCKETS);
  localparam int UW      = $clog2(NUM_BUCKETS + 1);
  localparam int FW      = $clog2(BUCKET_SLOTS + 1);
  localparam int AW      = $clog2(NUM_BUCKETS * BUCKET_SLOTS);
  localparam int CW      = (DW + 1 > FW) ? DW + 1 : FW;
  localparam int NSlots  = NUM_BUCKETS * BUCKET_SLOTS;

  // memories
  logic [BW:0]             dir_mem  [DirSize];
  logic [GDW-1:0]          ld_mem   [NUM_BUCKETS];
  logic [FW-1:0]           fill_mem [NUM_BUCKETS];
  logic [KeyW-1:0]         key_mem  [NSlots];
  logic [PAYLOAD_BITS-1:0] pay_mem  [NSlots];

  logic [BW:0]             dir_rq;
  logic [GDW-1:0]          ld_rq;
  logic [FW-1:0]           fill_rq;
  logic [KeyW-1:0]         skey_rq;
  logic [PAYLOAD_BITS-1:0] spay_rq;

  logic [GDW-1:0]          gd_q;
  logic [UW-1:0]           used_q;
  logic [CW-1:0]           cnt_q;
  logic [CountW-1:0]       n_q;
  logic                    pend_v_q;
  logic                    out_valid_q;
  logic [FW-1:0]           keep_q, move_q;

  logic                    cmd_q;
  logic [KeyW-1:0]         key_q;
  logic [PAYLOAD_BITS-1:0] pay_q, pend_q;
  logic [BW-1:0]           b_q, nb_q;
  logic [StatW-1:0]        out_status_q;
  logic [KeyW-1:0]         out_key_q;
  logic [PayW-1:0]         out_pay_q;
  logic                    out_last_q;

  logic [DW-1:0]  dir_mask, idx;
  logic [DW:0]    size;
  logic [CW-1:0]  cnt_plus;
  logic           emit, move_bit;

  logic           dir_we, dir_re;
  logic [DW-1:0]  dir_wa, dir_ra;
  logic [BW:0]    dir_wd;
  logic           ld_we, fill_we, bk_re, slot_we, slot_re;
  logic [BW-1:0]  ld_wa, fill_wa, bk_ra;
  logic [GDW-1:0] ld_wd;
  logic [FW-1:0]  fill_wd;
  logic [AW-1:0]  slot_wa, slot_ra;
  logic [KeyW-1:0]         slot_wk;
  logic [PAYLOAD_BITS-1:0] slot_wp;

  assign dir_mask = ~({DW{1'b1}} << gd_q);
  assign idx      = key_q[DW-1:0] & dir_mask;
  assign size     = (DW + 1)'(1) << gd_q;
  assign cnt_plus = cnt_q + CW'(size);
  assign move_bit = skey_rq[ld_rq];
  assign emit     = (cmd_i.op == OP_OUT) || (cmd_i.op == OP_HIT && pend_v_q);

  always_comb begin
    dir_we  = 1'b0;
    dir_wa  = cnt_q[DW-1:0];
    dir_wd  = '0;
    dir_re  = 1'b0;
    dir_ra  = cnt_q[DW-1:0];
    ld_we   = 1'b0;
    ld_wa   = b_q;
    ld_wd   = GDW'(ld_rq + 1'b1);
    fill_we = 1'b0;
    fill_wa = b_q;
    fill_wd = FW'(fill_rq + 1'b1);
    bk_re   = 1'b0;
    bk_ra   = dir_rq[BW-1:0];
    slot_we = 1'b0;
    slot_wa = AW'(b_q) * AW'(BUCKET_SLOTS) + AW'(fill_rq);
    slot_wk = key_q;
    slot_wp = pay_q;
    slot_re = 1'b0;
    slot_ra = AW'(b_q) * AW'(BUCKET_SLOTS) + AW'(cnt_q);
    case (cmd_i.op)
      OP_CLEAR: begin
        dir_we = 1'b1;
      end
      OP_DIR_RD: begin
        dir_re = 1'b1;
        dir_ra = idx;
      end
      OP_DIR_RD_CNT: begin
        dir_re = 1'b1;
      end
      OP_BKT_RD: begin
        bk_re = 1'b1;
      end
      OP_ALLOC: begin
        dir_we  = 1'b1;
        dir_wa  = idx;
        dir_wd  = {1'b1, used_q[BW-1:0]};
        ld_we   = 1'b1;
        ld_wa   = used_q[BW-1:0];
        ld_wd   = gd_q;
        fill_we = 1'b1;
        fill_wa = used_q[BW-1:0];
        fill_wd = FW'(1);
        slot_we = 1'b1;
        slot_wa = AW'(used_q[BW-1:0]) * AW'(BUCKET_SLOTS);
      end
      OP_INS: begin
        fill_we = 1'b1;
        slot_we = 1'b1;
      end
      OP_SPLIT1: begin
        ld_we = 1'b1;
      end
      OP_SPLIT2: begin
        ld_we = 1'b1;
        ld_wa = nb_q;
      end
      OP_SPL_DWR: begin
        // entries of the old bucket with the split bit set move to the new one
        dir_we = dir_rq[BW] && (dir_rq[BW-1:0] == b_q) && cnt_q[ld_rq];
        dir_wd = {1'b1, nb_q};
      end
      OP_DBL_WR: begin
        dir_we = 1'b1;
        dir_wa = cnt_plus[DW-1:0];
        dir_wd = dir_rq;
      end
      OP_SLOT_RD: begin
        slot_re = 1'b1;
      end
      OP_SPL_SWR: begin
        slot_we = 1'b1;
        slot_wk = skey_rq;
        slot_wp = spay_rq;
        slot_wa = move_bit ? AW'(nb_q) * AW'(BUCKET_SLOTS) + AW'(move_q)
                           : AW'(b_q) * AW'(BUCKET_SLOTS) + AW'(keep_q);
      end
      OP_SPL_F1: begin
        fill_we = 1'b1;
        fill_wd = keep_q;
      end
      OP_SPL_F2: begin
        fill_we = 1'b1;
        fill_wa = nb_q;
        fill_wd = move_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (dir_re) dir_rq <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) ld_mem[ld_wa] <= ld_wd;
    if (bk_re) ld_rq <= ld_mem[bk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (bk_re) fill_rq <= fill_mem[bk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem[slot_wa] <= slot_wk;
      pay_mem[slot_wa] <= slot_wp;
    end
    if (slot_re) begin
      skey_rq <= key_mem[slot_ra];
      spay_rq <= pay_mem[slot_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_q        <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      keep_q      <= '0;
      move_q      <= '0;
    end else begin
      case (cmd_i.op)
        OP_CLEAR, OP_SPL_DWR, OP_DBL_WR, OP_CNT_INC: cnt_q <= cnt_q + 1'b1;
        OP_TAKE: begin
          n_q      <= '0;
          pend_v_q <= 1'b0;
        end
        OP_BKT_RD: cnt_q <= '0;
        OP_ALLOC: used_q <= used_q + 1'b1;
        OP_SPLIT1: begin
          used_q <= used_q + 1'b1;
          cnt_q  <= '0;
        end
        OP_CNT0: begin
          cnt_q  <= '0;
          keep_q <= '0;
          move_q <= '0;
        end
        OP_SPL_SWR: begin
          cnt_q <= cnt_q + 1'b1;
          if (move_bit) move_q <= move_q + 1'b1;
          else keep_q <= keep_q + 1'b1;
        end
        OP_GD_INC: gd_q <= gd_q + 1'b1;
        OP_HIT: begin
          pend_v_q <= 1'b1;
          n_q      <= n_q + 1'b1;
          cnt_q    <= cnt_q + 1'b1;
        end
        default: ;
      endcase
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.cfg_we) begin
        gd_q   <= (cfg_data_i > CfgW'(MAX_DEPTH)) ? GDW'(MAX_DEPTH) : GDW'(cfg_data_i);
        used_q <= '0;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_TAKE) begin
      cmd_q <= command_i;
      key_q <= key_i;
      pay_q <= payload_i[PAYLOAD_BITS-1:0];
    end
    if (cmd_i.op == OP_BKT_RD) b_q <= dir_rq[BW-1:0];
    if (cmd_i.op == OP_SPLIT1) nb_q <= used_q[BW-1:0];
    if (cmd_i.op == OP_HIT) pend_q <= spay_rq;
    if (emit) begin
      out_key_q <= key_q;
      if (cmd_i.op == OP_HIT) begin
        out_status_q <= ST_MATCH;
        out_pay_q    <= PayW'(pend_q);
        out_last_q   <= 1'b0;
      end else begin
        out_status_q <= cmd_i.res;
        out_pay_q    <= (cmd_i.res == ST_MATCH) ? PayW'(pend_q) : '0;
        out_last_q   <= cmd_i.last;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_key_o     = out_key_q;
  assign found_payload_o = out_pay_q;
  assign last_o          = out_last_q;

  assign sts_o.lookup      = (cmd_q == CMD_LOOKUP);
  assign sts_o.dir_v       = dir_rq[BW];
  assign sts_o.fill_full   = (fill_rq == FW'(BUCKET_SLOTS));
  assign sts_o.ld_lt_gd    = (ld_rq < gd_q);
  assign sts_o.used_full   = (used_q == UW'(NUM_BUCKETS));
  assign sts_o.gd_max      = (gd_q == GDW'(MAX_DEPTH));
  assign sts_o.clr_last    = (cnt_q == CW'(DirSize - 1));
  assign sts_o.cnt_eq_size = (cnt_q == CW'(size));
  assign sts_o.cnt_eq_fill = (cnt_q == CW'(fill_rq));
  assign sts_o.scan_end    = (cnt_q == CW'(fill_rq)) || (n_q == CountW'(ResultCap));
  assign sts_o.hit         = (skey_rq == key_q);
  assign sts_o.pend_v      = pend_v_q;
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;

endmodule

// ----- rtl/extendible_hash_table.sv -----
// channel   signals                                    direction
// cfg       cfg_valid_i cfg_ready_o cfg_data_i         in  (initial depth, clears table)
// in        in_valid_i in_ready_o command_i key_i      in
//           payload_i
// out       out_valid_o out_ready_i status_o           out (one beat per insert,
//           found_key_o found_payload_o last_o              1..8 per lookup)
//
// lookup: no scan on an empty entry, else the bucket's slots are scanned, one slot read each
// split: the directory entries are rewritten, then the bucket slots redistributed; doubling copies the directory
// after reset and after each cfg beat all 2^MAX_DEPTH directory entries are cleared, no input taken
// a stalled out beat holds the sequencer only when a next beat is ready to go
module extendible_hash_table import eht_pkg::*; #(
  parameter int MAX_DEPTH    = 8,
  parameter int BUCKET_SLOTS = 8,
  parameter int NUM_BUCKETS  = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   command_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [PayW-1:0]        payload_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [StatW-1:0]       status_o,
  output logic signed [KeyW-1:0] found_key_o,
  output logic [PayW-1:0]        found_payload_o,
  output logic                   last_o
);

  cmd_t cmd;
  sts_t sts;

  eht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eht_dp #(
    .MAX_DEPTH    (MAX_DEPTH),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .NUM_BUCKETS  (NUM_BUCKETS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .last_o          (last_o)
  );

endmodule

// ----- bench/tb_extendible_hash_table.sv -----
`timescale 1ns / 100ps

module tb_extendible_hash_table;
  import eht_pkg::*;

  localparam int MaxDepth    = 8;
  localparam int BucketSlots = 8;
  localparam int NumBuckets  = 256;
  localparam int DirSize     = 1 << MaxDepth;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  key;
    logic [PayW-1:0]  payload;
    logic             last;
  } hash_beat_t;

  int errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  class hash_scoreboard;
    int          depth;
    bit          dir_v [DirSize];
    int          dir_b [DirSize];
    int          ldepth[NumBuckets];
    int          fill  [NumBuckets];
    logic [31:0] skey  [NumBuckets*BucketSlots];
    logic [63:0] spay  [NumBuckets*BucketSlots];
    int          used;
    hash_beat_t  pending[$];
    int          beats_seen;

    function void clear(input int d);
      for (int i = 0; i < DirSize; i++) dir_v[i] = 0;
      for (int i = 0; i < NumBuckets; i++) fill[i] = 0;
      used = 0;
      depth = (d > MaxDepth) ? MaxDepth : d;
    endfunction

    function void split(input int b);
      int nb;
      int ld;
      int keep;
      int move;
      logic [31:0] k;
      logic [63:0] p;
      nb = used;
      used++;
      ld = ldepth[b];
      keep = 0;
      move = 0;
      ldepth[b] = ld + 1;
      ldepth[nb] = ld + 1;
      for (int i = 0; i < (1 << depth); i++)
        if (dir_v[i] && dir_b[i] == b && ((i >> ld) & 1)) dir_b[i] = nb;
      for (int i = 0; i < fill[b]; i++) begin
        k = skey[b*BucketSlots+i];
        p = spay[b*BucketSlots+i];
        if (k[ld]) begin
          skey[nb*BucketSlots+move] = k;
          spay[nb*BucketSlots+move] = p;
          move++;
        end else begin
          skey[b*BucketSlots+keep] = k;
          spay[b*BucketSlots+keep] = p;
          keep++;
        end
      end
      fill[b] = keep;
      fill[nb] = move;
    endfunction

    function logic [StatW-1:0] insert(input logic [31:0] key, input logic [63:0] pay);
      int idx;
      int b;
      int sz;
      for (int t = 0; t < 2*MaxDepth+4; t++) begin
        idx = key & ((1 << depth) - 1);
        if (!dir_v[idx]) begin
          if (used >= NumBuckets) return ST_NO_BUCKET;
          b = used;
          used++;
          dir_v[idx] = 1;
          dir_b[idx] = b;
          ldepth[b] = depth;
          fill[b] = 0;
        end
        b = dir_b[idx];
        if (fill[b] < BucketSlots) begin
          skey[b*BucketSlots+fill[b]] = key;
          spay[b*BucketSlots+fill[b]] = pay;
          fill[b]++;
          return ST_INSERTED;
        end
        if (ldepth[b] < depth) begin
          if (used >= NumBuckets) return ST_NO_BUCKET;
          split(b);
        end else begin
          if (depth >= MaxDepth) return ST_FULL;
          sz = 1 << depth;
          for (int i = 0; i < sz; i++) begin
            dir_v[i+sz] = dir_v[i];
            dir_b[i+sz] = dir_b[i];
          end
          depth++;
        end
      end
      return ST_FULL;
    endfunction

    function void note_item(input logic cmd, input logic [31:0] key, input logic [63:0] pay);
      int idx;
      int b;
      int n;
      if (cmd == CMD_INSERT) begin
        pending.push_back({insert(key, pay), key, 64'd0, 1'b1});
        return;
      end
      idx = key & ((1 << depth) - 1);
      n = 0;
      if (dir_v[idx]) begin
        b = dir_b[idx];
        for (int i = 0; i < fill[b] && n < ResultCap; i++)
          if (skey[b*BucketSlots+i] == key) begin
            pending.push_back({ST_MATCH, key, spay[b*BucketSlots+i], 1'b0});
            n++;
          end
      end
      if (n == 0) pending.push_back({ST_NOT_FOUND, key, 64'd0, 1'b1});
      else pending[$].last = 1'b1;
    endfunction

    task check_beat(input hash_beat_t got);
      hash_beat_t want;
      beats_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d want %0d key %h", got.status, want.status, want.key));
      if (got.key !== want.key)
        report_mismatch($sformatf("found_key %h want %h", got.key, want.key));
      if (got.payload !== want.payload)
        report_mismatch($sformatf("found_payload %h want %h", got.payload, want.payload));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b want %b key %h", got.last, want.last, want.key));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CfgW-1:0]   cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              command;
  logic [KeyW-1:0]   key;
  logic [PayW-1:0]   payload;
  logic              out_valid;
  logic              out_ready;
  logic [StatW-1:0]  status;
  logic [KeyW-1:0]   found_key;
  logic [PayW-1:0]   found_payload;
  logic              last;

  hash_scoreboard table_sb = new();
  bit                quiet = 0;
  int                items_sent = 0;

  extendible_hash_table dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .key_i(key), .payload_i(payload),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .found_key_o(found_key), .found_payload_o(found_payload),
    .last_o(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stall bursts until the quiet tail
  initial begin
    int stall;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        stall = $urandom_range(1, 15);
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      table_sb.check_beat({status, found_key, found_payload, last});

  task automatic write_depth(input logic [CfgW-1:0] d);
    cfg_valid <= 1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    table_sb.clear(d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_item(input logic cmd, input logic [31:0] k, input logic [63:0] p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1;
    command  <= cmd;
    key      <= k;
    payload  <= p;
    do @(posedge clk); while (!in_ready);
    table_sb.note_item(cmd, k, p);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (table_sb.pending.size() != 0) @(negedge clk);
    // idle gap after the last beat of an item
    repeat (1200) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // keys from a small pool share buckets so splits, doubling and repeats happen
  function automatic logic [31:0] pool_key(input int spread);
    logic [31:0] k;
    k = $urandom_range(0, spread);
    if ($urandom_range(0, 3) == 0) k[31:24] = 8'($urandom());
    return k;
  endfunction

  initial begin
    logic [31:0] k;
    table_sb.beats_seen = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_valid = 0;
    command = CMD_INSERT;
    key = '0;
    payload = '0;
    table_sb.clear(0);
    repeat (3) @(negedge clk);
    rst_n = 1;

    // directed: empty lookup, extremes, repeated key past eight matches
    send_item(CMD_LOOKUP, 32'h0, 64'h0);
    send_item(CMD_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_INSERT, 32'h7FFF_FFFF, 64'h0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    send_item(CMD_LOOKUP, 32'h8000_0000, 64'h0);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_LOOKUP, 32'h1234_5678, 64'h0);
    for (int i = 0; i < 10; i++) send_item(CMD_INSERT, 32'h0000_0040, 64'(i) << 56 | 64'(i));
    send_item(CMD_LOOKUP, 32'h0000_0040, 64'h0);
    drain();

    // same low bits fill one bucket at full depth: table full
    write_depth(4'd15);
    for (int i = 0; i < 10; i++) send_item(CMD_INSERT, 32'(i) << 8 | 32'h3, rand64());
    send_item(CMD_LOOKUP, 32'h0000_0103, 64'h0);
    drain();

    // depth zero, dense low keys: splits and doubling from an empty directory
    write_depth(4'd0);
    for (int i = 0; i < 60; i++) send_item(CMD_INSERT, i, rand64());
    send_item(CMD_LOOKUP, 32'd37, 64'h0);
    drain();

    // random phases across depth settings
    for (int ph = 0; ph < 4; ph++) begin
      write_depth(ph == 0 ? 4'd8 : ph == 1 ? 4'd3 : ph == 2 ? 4'd0 : 4'($urandom_range(0, 15)));
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 60; i++) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom() : pool_key(ph == 0 ? 600 : 60);
        send_item($urandom_range(0, 2) == 0 ? CMD_LOOKUP : CMD_INSERT, k, rand64());
      end
      drain();
    end

    $display("sent %0d items, checked %0d result beats", items_sent, table_sb.beats_seen);
    $display("covered depth settings 0, 3, 8, 15, bucket splits, doubling, full table");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/eht_pkg.sv
rtl/eht_ctrl.sv
rtl/eht_dp.sv
rtl/extendible_hash_table.sv
bench/tb_extendible_hash_table.sv
